@@ rtl/dtmp_pkg.sv @@
package dtmp_pkg;

  localparam int SLOTS   = 64;
  localparam int OP_W    = 2;
  localparam int KEY_W   = 7;
  localparam int VAL_W   = 31;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int IN_W    = 40;
  localparam int OUT_W   = 48;
  localparam int OUT_USED = STAT_W + KEY_W + VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_FINDMAX = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_DUP      = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_RANGE    = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    RES_ACCESS = 2'd0,
    RES_RANGE  = 2'd1,
    RES_EMPTY  = 2'd2,
    RES_MAXHIT = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      req_load;
    logic      rd_en;
    logic      rd_key;
    logic      idx_clr;
    logic      idx_inc;
    logic      scan_init;
    logic      max_upd;
    logic      rem_dec;
    logic      out_load;
    res_kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_rng;
    logic idx_last;
    logic best_zero;
    logic hit;
    logic rem_one;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/dtmp_ctrl.sv @@
module dtmp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  dtmp_pkg::sts_t st,
  output dtmp_pkg::cmd_t cmd
);
  import dtmp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ACC_RD   = 10'b0000000010,
    S_ACC_EX   = 10'b0000000100,
    S_RANGE    = 10'b0000001000,
    S_SCAN1    = 10'b0000010000,
    S_TAIL     = 10'b0000100000,
    S_DECIDE   = 10'b0001000000,
    S_EMPTY    = 10'b0010000000,
    S_SCAN2_RD = 10'b0100000000,
    S_SCAN2_CK = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_kind = RES_ACCESS;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.req_load = 1'b1;
          unique case (st.in_op) inside
            OP_INSERT, OP_LOOKUP: begin
              state_next = st.in_rng ? S_ACC_RD : S_RANGE;
            end
            OP_FINDMAX: begin
              cmd.idx_clr   = 1'b1;
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN1;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ACC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_key = 1'b1;
        state_next = S_ACC_EX;
      end
      S_ACC_EX: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RES_ACCESS;
          state_next   = S_IDLE;
        end
      end
      S_RANGE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RES_RANGE;
          state_next   = S_IDLE;
        end
      end
      S_SCAN1: begin
        cmd.rd_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.max_upd = 1'b1;
        if (st.idx_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.max_upd = 1'b1;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.idx_clr = 1'b1;
        state_next  = st.best_zero ? S_EMPTY : S_SCAN2_RD;
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RES_EMPTY;
          state_next   = S_IDLE;
        end
      end
      S_SCAN2_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SCAN2_CK;
      end
      S_SCAN2_CK: begin
        if (!st.hit) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN2_RD;
        end else if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = RES_MAXHIT;
          cmd.rem_dec  = 1'b1;
          if (st.rem_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN2_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/dtmp_datapath.sv @@
module dtmp_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dtmp_pkg::IN_W-1:0]   s_tdata,
  input  dtmp_pkg::cmd_t              cmd,
  output dtmp_pkg::sts_t              st,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dtmp_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast
);
  import dtmp_pkg::*;

  logic [VAL_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] slot_vld;

  op_t              req_op;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] key_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic             rd_vld;
  logic             rd_pend;
  logic [VAL_W-1:0] rd_value;
  logic [VAL_W-1:0] best;
  logic [CNT_W-1:0] cnt;
  logic             wr_en;

  logic [STAT_W-1:0] out_stat,  out_stat_next;
  logic [KEY_W-1:0]  out_key,   out_key_next;
  logic [VAL_W-1:0]  out_val,   out_val_next;
  logic              out_last,  out_last_next;

  logic [KEY_W-1:0] in_key;
  logic [KEY_W-1:0] key_m1;

  assign in_key   = s_tdata[OP_W +: KEY_W];
  assign key_m1   = req_key - KEY_W'(1);
  assign key_idx  = key_m1[IDX_W-1:0];
  assign rd_addr  = cmd.rd_key ? key_idx : idx;
  assign rd_value = rd_vld ? rd_data : '0;

  assign st.in_op     = op_t'(s_tdata[OP_W-1:0]);
  assign st.in_rng    = (in_key != '0) && (in_key <= KEY_W'(SLOTS));
  assign st.idx_last  = (idx == IDX_W'(SLOTS - 1));
  assign st.best_zero = (best == '0);
  assign st.hit       = (rd_value == best);
  assign st.rem_one   = (cnt == CNT_W'(1));
  assign st.out_free  = !m_tvalid || m_tready;

  assign wr_en = cmd.out_load && (cmd.out_kind == RES_ACCESS) &&
                 (req_op == OP_INSERT) && (rd_value == '0);

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_op  <= op_t'(s_tdata[OP_W-1:0]);
      req_key <= in_key;
      req_val <= s_tdata[OP_W+KEY_W +: VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[key_idx] <= req_val;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      rd_vld   <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (wr_en) begin
        slot_vld[key_idx] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld <= slot_vld[rd_addr];
      end
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best <= '0;
      cnt  <= '0;
    end else if (cmd.max_upd && rd_pend) begin
      if (rd_value > best) begin
        best <= rd_value;
        cnt  <= CNT_W'(1);
      end else if (rd_value == best && rd_value != '0) begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (cmd.rem_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_comb begin
    out_stat_next = STAT_OK;
    out_key_next  = req_key;
    out_val_next  = '0;
    out_last_next = 1'b1;
    case (cmd.out_kind)
      RES_ACCESS: begin
        if (req_op == OP_INSERT) begin
          out_stat_next = (rd_value != '0) ? STAT_DUP : STAT_OK;
        end else if (rd_value == '0) begin
          out_stat_next = STAT_NOTFOUND;
        end else begin
          out_val_next = rd_value;
        end
      end
      RES_RANGE: out_stat_next = STAT_RANGE;
      RES_EMPTY: begin
        out_stat_next = STAT_EMPTY;
        out_key_next  = '0;
      end
      RES_MAXHIT: begin
        out_key_next  = KEY_W'(idx) + KEY_W'(1);
        out_val_next  = best;
        out_last_next = (cnt == CNT_W'(1));
      end
      default: out_stat_next = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stat <= out_stat_next;
      out_key  <= out_key_next;
      out_val  <= out_val_next;
      out_last <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{(OUT_W - OUT_USED){1'b0}}, out_val, out_key, out_stat};
  assign m_tlast = out_last;

endmodule

@@ rtl/direct_table_with_max_positions.sv @@
// Direct-address table of 64 slots with a search for the greatest value and its keys.
// Requests enter on the s_ channel: insert, lookup or find-max, with a key and a value.
// Results leave on the m_ channel, and m_tlast marks the final result of each request.
// Insert and lookup read the slot in S_ACC_RD and give one result from S_ACC_EX when the
// output is free; an out-of-range key gives its result from S_RANGE, then the block is ready.
// Find-max first reads every slot through the single read port, one slot a cycle, in
// S_SCAN1, with S_TAIL taking in the last read; a second pass then reads each slot it examines
// in S_SCAN2_RD, checks it in S_SCAN2_CK and stops after the last key holding the maximum.
// An empty table gives a single table-empty result; an out-of-range key gives one result.
// One request is taken at a time: s_tready is high only while the block is idle, and it
// may be high while the previous result still waits in the output register.
// When the receiver stalls, the result is held in the output register and the block
// waits before producing another one.
// Reset clears the valid flag of every slot at once, so the table is empty in the
// first cycle after reset and no clearing pass is needed.
module direct_table_with_max_positions (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation [1:0], key [8:2], value_in [39:9]
  input  logic [dtmp_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status [2:0], key_out [9:3], value_out [40:10], zeros above
  output logic [dtmp_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast
);
  import dtmp_pkg::*;

  cmd_t cmd;
  sts_t st;

  dtmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  dtmp_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result register loaded while a result is still pending");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (st.in_op != OP_NONE) |=> !s_tready)
    else $error("second request taken before the first was served");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STAT_W-1:0] == STAT_EMPTY) |-> m_tlast)
    else $error("table-empty result not marked as last");
`endif

endmodule
